>>> src/pvd_pkg.sv
// shared types and constants of the polynomial value and derivatives unit
package pvd_pkg;

    // fixed point format
    localparam int Q_W       = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * Q_W;
    localparam int RND_W     = PROD_W - FRAC_BITS;
    localparam int DC_W      = 40;
    localparam int SUM_W     = 50;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W - 1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W - 1){1'b0}}};

    // lanes: value, first and second derivative
    localparam int NUM_LANES  = 3;
    localparam int LANE_VALUE = 0;
    localparam int LANE_D1    = 1;
    localparam int LANE_D2    = 2;

    // configuration registers
    localparam int NUM_COEFF = 6;
    localparam int CIDX_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int TC_W      = 3;
    localparam int IDX_W     = 5;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 3'd0;
    localparam int REG_COEFF_BASE = 1;

    // one word as it moves from step to step
    typedef struct packed {
        logic [Q_W-1:0]                x;
        logic [NUM_LANES-1:0][Q_W-1:0] acc;
        logic                          ovf;
    } pvd_word_t;

    typedef logic [NUM_LANES-1:0][DC_W-1:0]   dc_vec_t;
    typedef logic [NUM_LANES-1:0][PROD_W-1:0] prod_vec_t;

endpackage

>>> src/pvd_step.sv
// one horner step for all three lanes: multiply stage then round, add and saturate stage
module pvd_step
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pvd_pkg::pvd_word_t in_word,
    input  pvd_pkg::dc_vec_t   dc,
    output logic               out_valid,
    input  logic               out_ready,
    output pvd_pkg::pvd_word_t out_word
);
    import pvd_pkg::*;

    logic      a_valid_reg;
    logic      a_valid_next;
    logic [Q_W-1:0] a_x_reg;
    logic      a_ovf_reg;
    prod_vec_t a_prod_reg;
    prod_vec_t a_prod_next;

    logic      b_valid_reg;
    logic      b_valid_next;
    pvd_word_t b_word_reg;
    pvd_word_t b_word_next;

    logic a_ready;
    logic b_ready;

    logic signed [PROD_W-1:0] rnd_full [NUM_LANES];
    logic signed [RND_W-1:0]  rnd      [NUM_LANES];
    logic signed [SUM_W-1:0]  sum      [NUM_LANES];
    logic [NUM_LANES-1:0]     sat_hi;
    logic [NUM_LANES-1:0]     sat_lo;

    // per stage ready, a stage with a bubble always takes a word
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage a: accumulator times x
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            a_prod_next[l] = PROD_W'($signed(in_word.acc[l])) * PROD_W'($signed(in_word.x));
        end
        a_valid_next = a_ready ? in_valid : a_valid_reg;
    end

    // stage b: round half up, add derivative coefficient, saturate
    always_comb
    begin
        b_word_next.x   = a_x_reg;
        b_word_next.ovf = a_ovf_reg;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            rnd_full[l] = $signed(a_prod_reg[l]) + PROD_W'(ROUND_HALF);
            rnd[l]      = rnd_full[l][PROD_W-1:FRAC_BITS];
            sum[l]      = SUM_W'(rnd[l]) + SUM_W'($signed(dc[l]));
            sat_hi[l]   = !sum[l][SUM_W-1] && (|sum[l][SUM_W-2:Q_W-1]);
            sat_lo[l]   = sum[l][SUM_W-1] && !(&sum[l][SUM_W-2:Q_W-1]);
            if (sat_hi[l])
            begin
                b_word_next.acc[l] = Q_MAX;
            end
            else if (sat_lo[l])
            begin
                b_word_next.acc[l] = Q_MIN;
            end
            else
            begin
                b_word_next.acc[l] = sum[l][Q_W-1:0];
            end
        end
        if ((|sat_hi) || (|sat_lo))
        begin
            b_word_next.ovf = 1'b1;
        end
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_x_reg    <= in_word.x;
            a_ovf_reg  <= in_word.ovf;
            a_prod_reg <= a_prod_next;
        end
        if (a_valid_reg && b_ready)
        begin
            b_word_reg <= b_word_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_word  = b_word_reg;

endmodule

>>> src/polynomial_value_and_derivatives_unit.sv
// top level of the polynomial value and derivatives unit
// Evaluates a Q16.16 polynomial of up to MAX_TERMS coefficients (highest
// power first) together with its first and second derivatives at one point x
// per input word, each by Horner's rule with rounding half up and saturation
// at every step; overflow reports any saturation. The unit takes one word
// every cycle while the output is not stalled, and each word passes through
// the chain of Horner steps, each a multiply stage and an add and saturate
// stage. Configuration writes are always taken (cfg_ready is tied high) and
// must only be made while no word is in flight; the derivative coefficient
// table is registered from the coefficient registers and follows a write
// behind them. A term count of zero acts as one, and above MAX_TERMS as MAX_TERMS.
module polynomial_value_and_derivatives_unit
#(
    parameter int MAX_TERMS = 6
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pvd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pvd_pkg::Q_W-1:0]               cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pvd_pkg::Q_W-1:0]        x,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pvd_pkg::Q_W-1:0]        value,
    output logic signed [pvd_pkg::Q_W-1:0]        first_deriv,
    output logic signed [pvd_pkg::Q_W-1:0]        second_deriv,
    output logic                                  overflow
);
    import pvd_pkg::*;

    logic [TC_W-1:0]                term_count_reg;
    logic [TC_W-1:0]                term_count_next;
    logic [NUM_COEFF-1:0][Q_W-1:0]  coeff_reg;
    logic [NUM_COEFF-1:0][Q_W-1:0]  coeff_next;
    logic [TC_W-1:0]                n_eff;

    dc_vec_t [MAX_TERMS-1:0]        dc_reg;
    dc_vec_t [MAX_TERMS-1:0]        dc_next;

    logic      stage_valid [MAX_TERMS+1];
    logic      stage_ready [MAX_TERMS+1];
    pvd_word_t stage_word  [MAX_TERMS+1];

    // configuration writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        term_count_next = term_count_reg;
        coeff_next      = coeff_reg;
        if (cfg_valid && cfg_index == REG_TERM_COUNT)
        begin
            term_count_next = cfg_data[TC_W-1:0];
        end
        for (int i = 0; i < NUM_COEFF; i++)
        begin
            if (cfg_valid && cfg_index == CFG_IDX_W'(REG_COEFF_BASE + i))
            begin
                coeff_next[i] = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TC_W'(1);
            coeff_reg      <= '0;
        end
        else
        begin
            term_count_reg <= term_count_next;
            coeff_reg      <= coeff_next;
        end
    end

    // term count limited to one .. MAX_TERMS
    always_comb
    begin
        if (term_count_reg == '0)
        begin
            n_eff = TC_W'(1);
        end
        else if (term_count_reg > TC_W'(MAX_TERMS))
        begin
            n_eff = TC_W'(MAX_TERMS);
        end
        else
        begin
            n_eff = term_count_reg;
        end
    end

    // derivative coefficient table, terms aligned to the last step so that
    // leading steps see zero and leave the accumulator at zero
    for (genvar k = 0; k < MAX_TERMS; k++)
    begin : g_step_dc
        for (genvar d = 0; d < NUM_LANES; d++)
        begin : g_lane_dc
            localparam int OFFSET = k - MAX_TERMS - d;
            localparam int MULT   = (d == 0) ? 1 :
                                    (d == 1) ? (MAX_TERMS - k) :
                                    (MAX_TERMS + 1 - k) * (MAX_TERMS - k);
            logic signed [IDX_W-1:0] idx;
            logic [Q_W-1:0]          csel;

            assign idx  = $signed(IDX_W'(n_eff)) + $signed(IDX_W'(OFFSET));
            assign csel = (!idx[IDX_W-1] && idx < $signed(IDX_W'(NUM_COEFF)))
                          ? coeff_reg[idx[CIDX_W-1:0]] : '0;
            assign dc_next[k][d] = DC_W'($signed(csel)) * DC_W'(MULT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg <= '0;
        end
        else
        begin
            dc_reg <= dc_next;
        end
    end

    // horner chain
    assign stage_valid[0]     = in_valid;
    assign in_ready           = stage_ready[0];
    assign stage_word[0].x    = x;
    assign stage_word[0].acc  = '0;
    assign stage_word[0].ovf  = 1'b0;
    assign stage_ready[MAX_TERMS] = out_ready;

    for (genvar k = 0; k < MAX_TERMS; k++)
    begin : g_step
        pvd_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_word   (stage_word[k]),
            .dc        (dc_reg[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_word  (stage_word[k+1])
        );
    end

    // result word
    assign out_valid    = stage_valid[MAX_TERMS];
    assign value        = stage_word[MAX_TERMS].acc[LANE_VALUE];
    assign first_deriv  = stage_word[MAX_TERMS].acc[LANE_D1];
    assign second_deriv = stage_word[MAX_TERMS].acc[LANE_D2];
    assign overflow     = stage_word[MAX_TERMS].ovf;

    // input held back only when every stage is full and the output stalls
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while a stage had room");

    // term count write lands in the register
    a_term_count_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == REG_TERM_COUNT)
        |=> term_count_reg == $past(cfg_data[TC_W-1:0]))
        else $error("term count write lost");

    // the first step never carries a second derivative term
    a_first_step_d2_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dc_reg[0][LANE_D2] == '0)
        else $error("second derivative coefficient misaligned");

endmodule

>>> dv/tb.sv
// testbench for the polynomial value and derivatives unit
`timescale 1ns / 100ps

module tb;

    import pvd_pkg::*;

    localparam int     MAX_TERMS    = 6;
    localparam int     ITEM_TARGET  = 1950;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = 4 * MAX_TERMS;
    localparam int     RUN_LIMIT_NS = 10_000_000;
    localparam int     MAX_REPORTS  = 50;
    localparam longint SAT_HI       = 64'sd2147483647;
    localparam longint SAT_LO       = -64'sd2147483648;

    // no register sits behind this index
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // one result word as the unit should deliver it
    typedef struct {
        logic [Q_W-1:0] value;
        logic [Q_W-1:0] first_deriv;
        logic [Q_W-1:0] second_deriv;
        logic           overflow;
    } poly_eval_t;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [Q_W-1:0]              cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic signed [Q_W-1:0]       x         = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [Q_W-1:0]       value;
    logic signed [Q_W-1:0]       first_deriv;
    logic signed [Q_W-1:0]       second_deriv;
    logic                        overflow;

    // local copy of the programmed polynomial
    logic [TC_W-1:0]             terms_m;
    logic signed [Q_W-1:0]       coeff_m [NUM_COEFF];

    logic [Q_W-1:0]              points_q [$];
    poly_eval_t                  pending_evals [$];
    poly_eval_t                  want;
    int                          fail_count = 0;
    int                          tx_wait;
    int                          rx_wait;
    int                          hold_cnt;
    bit                          hold_req = 1'b0;
    bit                          tx_calm  = 1'b0;
    bit                          rx_calm  = 1'b0;

    polynomial_value_and_derivatives_unit #(.MAX_TERMS(MAX_TERMS)) DUT (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one Horner chain of the given derivative order, saturating every step
    function automatic logic [Q_W-1:0] horner(input int n, input int order,
                                              input logic [Q_W-1:0] xv, output bit sat);
        longint acc;
        longint dc;
        longint xs;
        int     i;
        int     j;
        sat = 1'b0;
        acc = 0;
        xs  = longint'($signed(xv));
        for (i = 0; i < n - order; i++)
        begin
            dc = (i < NUM_COEFF) ? longint'(coeff_m[i]) : 64'sd0;
            for (j = 0; j < order; j++)
                dc = dc * longint'(n - 1 - i - j);
            acc = ((acc * xs + ROUND_HALF) >>> FRAC_BITS) + dc;
            if (acc > SAT_HI)
            begin
                acc = SAT_HI;
                sat = 1'b1;
            end
            else if (acc < SAT_LO)
            begin
                acc = SAT_LO;
                sat = 1'b1;
            end
        end
        return acc[Q_W-1:0];
    endfunction

    // value and both derivatives at one point
    function automatic poly_eval_t eval_poly(input logic [Q_W-1:0] xv);
        poly_eval_t r;
        int         n;
        bit         s0;
        bit         s1;
        bit         s2;
        n = int'(terms_m);
        if (n < 1) n = 1;
        if (n > MAX_TERMS) n = MAX_TERMS;
        r.value        = horner(n, 0, xv, s0);
        r.first_deriv  = horner(n, 1, xv, s1);
        r.second_deriv = horner(n, 2, xv, s2);
        r.overflow     = s0 | s1 | s2;
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [Q_W-1:0] rand_point();
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 5))
                   0: return 32'h7FFF_FFFF;
                   1: return 32'h8000_0000;
                   2: return 32'h0000_0000;
                   3: return 32'hFFFF_FFFF;
                   4: return 32'h0001_0000;
                   default: return 32'hFFFF_0000;
               endcase
            1, 2: return $urandom;
            // within plus or minus four
            default: return int'($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic logic [Q_W-1:0] rand_coeff();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3, 4: return $urandom;
            // within plus or minus eight
            default: return int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    // append one point to the stimulus queue
    task automatic queue_point(input logic [Q_W-1:0] p);
        points_q.insert(points_q.size(), p);
    endtask

    // register file shadow, follows every accepted write
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terms_m <= TC_W'(1);
            for (int k = 0; k < NUM_COEFF; k++)
                coeff_m[k] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TERM_COUNT)
                terms_m <= cfg_data[TC_W-1:0];
            else if (cfg_index >= REG_COEFF_BASE && cfg_index < REG_COEFF_BASE + NUM_COEFF)
                coeff_m[cfg_index - REG_COEFF_BASE] <= cfg_data;
        end
    end

    // input driver: predicts each accepted word, then offers the next point
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            x        <= '0;
            tx_wait  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_evals.insert(pending_evals.size(), eval_poly(x));
            if (!in_valid || in_ready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (points_q.size() != 0)
                begin
                    x        <= points_q.pop_front();
                    in_valid <= 1'b1;
                    tx_wait  = idle_gap(tx_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_req)
            hold_cnt <= HOLD_CYCLES;
    end

    task automatic check_field(input string name, input logic [Q_W-1:0] exp_v,
                               input logic [Q_W-1:0] got_v);
        if (exp_v !== got_v)
        begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                         $time, name, $signed(exp_v), exp_v, $signed(got_v), got_v);
            fail_count++;
        end
    endtask

    // output monitor: checks each result word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_evals.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got value 0x%08h",
                                 $time, value);
                    fail_count++;
                end
                else
                begin
                    want = pending_evals.pop_front();
                    check_field("value", want.value, value);
                    check_field("first_deriv", want.first_deriv, first_deriv);
                    check_field("second_deriv", want.second_deriv, second_deriv);
                    check_field("overflow", Q_W'(want.overflow), Q_W'(overflow));
                end
                rx_wait = idle_gap(rx_calm);
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (hold_cnt == 0);
        end
    end

    // nothing queued, nothing offered, nothing outstanding
    task automatic wait_quiet();
        @(negedge clk);
        while (points_q.size() != 0 || in_valid || pending_evals.size() != 0)
            @(negedge clk);
    endtask

    // leaves cfg_valid high, the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_poly(input logic [TC_W-1:0] tc,
                            input logic [Q_W-1:0] c0, input logic [Q_W-1:0] c1,
                            input logic [Q_W-1:0] c2, input logic [Q_W-1:0] c3,
                            input logic [Q_W-1:0] c4, input logic [Q_W-1:0] c5);
        logic [Q_W-1:0] cs [NUM_COEFF];
        cs = '{c0, c1, c2, c3, c4, c5};
        wait_quiet();
        @(posedge clk);
        write_reg(REG_TERM_COUNT, Q_W'(tc));
        for (int k = 0; k < NUM_COEFF; k++)
            write_reg(CFG_IDX_W'(REG_COEFF_BASE + k), cs[k]);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // stimulus
    initial
    begin : stimulus
        int sent;
        int ph;
        int cnt;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: a single zero term
        queue_point(32'h7FFF_FFFF);
        queue_point(32'h8000_0000);
        queue_point(32'h0002_0000);

        // full order with extreme coefficients, plus a write to the empty index
        set_poly(3'd6, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000);
        wait_quiet();
        @(posedge clk);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        @(negedge clk);
        queue_point(32'h0000_0000);
        queue_point(32'h0001_0000);
        queue_point(32'hFFFF_0000);
        queue_point(32'h7FFF_FFFF);
        queue_point(32'h8000_0000);
        queue_point(32'hFFFF_FFFF);
        queue_point(32'h0000_0001);
        queue_point(32'h0000_8000);
        queue_point(32'hFFFF_8000);
        queue_point(32'h0001_8000);

        // term count zero acts as one
        set_poly(3'd0, 32'h0005_0000, 32'h0001_0000, 32'h0002_0000,
                 32'h0003_0000, 32'h0004_0000, 32'h0006_0000);
        queue_point(32'h0002_0000);
        queue_point(32'hFFFD_0000);

        // term count above the maximum acts as the maximum
        set_poly(3'd7, 32'h0000_4000, 32'hFFFF_0000, 32'h0002_0000,
                 32'hFFFD_0000, 32'h0001_0000, 32'h0000_C000);
        queue_point(32'h0001_8000);
        queue_point(32'hFFFE_8000);

        // two terms: second derivative has nothing left
        set_poly(3'd2, 32'h0003_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_point(32'h0004_0000);
        queue_point(32'h8000_0000);

        // an early step saturates, the last adds a large negative coefficient
        set_poly(3'd3, 32'h7FFF_0000, 32'h0000_0000, 32'h8001_0000,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_point(32'h0002_0000);
        queue_point(32'h0001_0000);

        // random settings, each phase drained before the next is programmed
        sent = 21;
        ph   = 0;
        while (sent < ITEM_TARGET)
        begin
            set_poly(TC_W'($urandom_range(0, 7)), rand_coeff(), rand_coeff(),
                     rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
            tx_calm = (ph % 5 == 3);
            rx_calm = (ph % 5 == 3);
            cnt     = $urandom_range(60, 200);
            if (ph == 1)
            begin
                // sender keeps offering while the receiver holds off
                tx_calm  = 1'b1;
                hold_req = 1'b1;
                cnt      = 150;
            end
            for (int k = 0; k < cnt; k++)
                queue_point(rand_point());
            if (hold_req)
            begin
                @(negedge clk);
                hold_req = 1'b0;
            end
            sent += cnt;
            ph++;
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
